// ----- hw/rtl/mcct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel compare timer package
// Shared sizes, command codes and the structures that pass between cells.
// ----------------------------------------------------------------------------
package mcct_pkg;

   localparam int CHANNELS   = 4;
   localparam int COUNT_BITS = 32;
   localparam int OUT_BITS   = 4;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic                  tick;
      logic                  start;
      logic                  stop;
      logic                  periodic;
      logic [COUNT_BITS-1:0] delay;
      logic [COUNT_BITS-1:0] count;
      logic [COUNT_BITS-1:0] count_next;
   } ctrl_type;

   typedef struct packed {
      logic [CHANNELS-1:0] fired;
      logic [CHANNELS-1:0] armed;
   } chain_type;

endpackage

// ----- hw/rtl/multi_channel_compare_timer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel compare timer
// A counter stepped by accepted ticks and a chain of compare channel cells
// that arm, fire, reload and disarm on tick, start and stop transactions.
// ----------------------------------------------------------------------------
// The block takes one transaction every clock cycle and returns its result
// in the next cycle from an output register. All channel cells compare against
// the new counter value in parallel in the accepting cycle, so the rate is set
// only by the output register: the input is stalled just while a result is
// held there and the result side stalls.
module multi_channel_compare_timer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [1:0]  req_channel,
   input  logic        req_periodic,
   input  logic [31:0] req_ticks,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_fired,
   output logic [3:0]  rsp_armed
);

   logic                                 accept;
   logic [mcct_pkg::COUNT_BITS-1:0]      count_ff;
   logic [mcct_pkg::COUNT_BITS-1:0]      count_in;
   mcct_pkg::ctrl_type                   ctrl;
   mcct_pkg::chain_type                  chain [mcct_pkg::CHANNELS+1];
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [mcct_pkg::OUT_BITS-1:0]        fired_ff;
   logic [mcct_pkg::OUT_BITS-1:0]        fired_in;
   logic [mcct_pkg::OUT_BITS-1:0]        armed_ff;
   logic [mcct_pkg::OUT_BITS-1:0]        armed_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      ctrl.tick       = 1'b0;
      ctrl.start      = 1'b0;
      ctrl.stop       = 1'b0;
      ctrl.periodic   = req_periodic;
      ctrl.delay      = req_ticks[mcct_pkg::COUNT_BITS-1:0];
      ctrl.count      = count_ff;
      ctrl.count_next = count_ff + 1'b1;
      case (req_cmd)
         mcct_pkg::CMD_TICK:  ctrl.tick  = accept;
         mcct_pkg::CMD_START: ctrl.start = accept;
         mcct_pkg::CMD_STOP:  ctrl.stop  = accept;
         default: ;
      endcase
      count_in = ctrl.tick ? ctrl.count_next : count_ff;
   end

   assign chain[0] = '0;

   for (genvar k = 0; k < mcct_pkg::CHANNELS; k++) begin : g_cell
      logic                          sel;
      logic [mcct_pkg::CHANNELS-1:0] cell_bit;

      assign sel      = (32'(req_channel) == k);
      assign cell_bit = mcct_pkg::CHANNELS'(1) << k;

      mcct_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .sel       (sel),
         .cell_bit  (cell_bit),
         .chain_in  (chain[k]),
         .chain_out (chain[k+1])
      );
   end

   for (genvar b = 0; b < mcct_pkg::OUT_BITS; b++) begin : g_out
      if (b < mcct_pkg::CHANNELS) begin : g_used
         assign fired_in[b] = chain[mcct_pkg::CHANNELS].fired[b];
         assign armed_in[b] = chain[mcct_pkg::CHANNELS].armed[b];
      end else begin : g_unused
         assign fired_in[b] = 1'b0;
         assign armed_in[b] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fired_ff <= fired_in;
         armed_ff <= armed_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_fired = fired_ff;
   assign rsp_armed = armed_ff;

endmodule

// ----- hw/rtl/mcct_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compare channel cell
// Holds one channel's deadline, reload interval and armed bit, and adds its
// own fired and armed bits to the masks handed along the chain.
// ----------------------------------------------------------------------------
module mcct_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  mcct_pkg::ctrl_type            ctrl,
   input  logic                          sel,
   input  logic [mcct_pkg::CHANNELS-1:0] cell_bit,
   input  mcct_pkg::chain_type           chain_in,
   output mcct_pkg::chain_type           chain_out
);

   logic [mcct_pkg::COUNT_BITS-1:0] deadline_ff;
   logic [mcct_pkg::COUNT_BITS-1:0] deadline_in;
   logic [mcct_pkg::COUNT_BITS-1:0] reload_ff;
   logic [mcct_pkg::COUNT_BITS-1:0] reload_in;
   logic                            armed_ff;
   logic                            armed_in;
   logic                            hit;

   always_comb begin
      deadline_in = deadline_ff;
      reload_in   = reload_ff;
      armed_in    = armed_ff;
      hit         = ctrl.tick && armed_ff && (deadline_ff == ctrl.count_next);
      if (hit) begin
         if (reload_ff != '0) begin
            deadline_in = ctrl.count_next + reload_ff;
         end else begin
            armed_in = 1'b0;
         end
      end
      if (ctrl.start && sel) begin
         deadline_in = ctrl.count + ctrl.delay;
         reload_in   = ctrl.periodic ? ctrl.delay : '0;
         armed_in    = 1'b1;
      end
      if (ctrl.stop && sel) begin
         reload_in = '0;
         armed_in  = 1'b0;
      end
      chain_out.fired = chain_in.fired | (hit ? cell_bit : '0);
      chain_out.armed = chain_in.armed | (armed_in ? cell_bit : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff <= '0;
         reload_ff   <= '0;
         armed_ff    <= 1'b0;
      end else begin
         deadline_ff <= deadline_in;
         reload_ff   <= reload_in;
         armed_ff    <= armed_in;
      end
   end

endmodule

// ----- sim/mcct_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compare timer result checker
// Watches all channels of the compare timer and predicts each result from
// its own copy of the counter, deadlines, reload intervals and armed mask.
// Results are matched in order against the queue of predicted results.
// ----------------------------------------------------------------------------
module mcct_checker
   import mcct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [1:0]  req_channel,
   input  logic        req_periodic,
   input  logic [31:0] req_ticks,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_fired,
   input  logic [3:0]  rsp_armed,
   output int          error_count,
   output int          pending,
   output int          result_count,
   output int          fire_count
);

   typedef struct packed {
      logic [OUT_BITS-1:0] fired;
      logic [OUT_BITS-1:0] armed;
   } timer_result;

   logic [COUNT_BITS-1:0] now_count;
   logic [COUNT_BITS-1:0] deadline [CHANNELS];
   logic [COUNT_BITS-1:0] reload [CHANNELS];
   logic [CHANNELS-1:0]   armed_mask;
   timer_result           predicted_results [$];
   int                    errors;
   int                    results;
   int                    fires;

   function automatic timer_result advance_timer(logic [1:0] cmd, logic [1:0] ch,
                                                 logic per, logic [COUNT_BITS-1:0] dly);
      timer_result         outcome;
      logic [CHANNELS-1:0] fired_mask;
      fired_mask = '0;
      case (cmd)
         CMD_TICK: begin
            now_count = now_count + 1'b1;
            for (int k = 0; k < CHANNELS; k++) begin
               if (armed_mask[k] && deadline[k] == now_count) begin
                  fired_mask[k] = 1'b1;
                  if (reload[k] != '0) begin
                     deadline[k] = now_count + reload[k];
                  end else begin
                     armed_mask[k] = 1'b0;
                  end
               end
            end
         end
         CMD_START: begin
            if (ch < CHANNELS) begin
               deadline[ch] = now_count + dly;
               reload[ch]   = per ? dly : '0;
               armed_mask[ch] = 1'b1;
            end
         end
         CMD_STOP: begin
            if (ch < CHANNELS) begin
               reload[ch]     = '0;
               armed_mask[ch] = 1'b0;
            end
         end
         default: begin
         end
      endcase
      outcome.fired = fired_mask[OUT_BITS-1:0];
      outcome.armed = armed_mask[OUT_BITS-1:0];
      return outcome;
   endfunction

   always @(posedge clock) begin
      timer_result want;
      timer_result got;
      if (reset) begin
         now_count  = '0;
         armed_mask = '0;
         for (int k = 0; k < CHANNELS; k++) begin
            deadline[k] = '0;
            reload[k]   = '0;
         end
         predicted_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.fired = rsp_fired;
            got.armed = rsp_armed;
            if (predicted_results.size() == 0) begin
               errors++;
               $error("Result with no transaction outstanding: fired %0h, armed %0h",
                      got.fired, got.armed);
            end else begin
               want = predicted_results.pop_front();
               if (got.fired !== want.fired) begin
                  errors++;
                  $error("rsp_fired mismatch: expected %0h, actual %0h", want.fired, got.fired);
               end
               if (got.armed !== want.armed) begin
                  errors++;
                  $error("rsp_armed mismatch: expected %0h, actual %0h", want.armed, got.armed);
               end
               results++;
               fires += $countones(got.fired);
            end
         end
         if (req_valid && !req_stall) begin
            predicted_results.push_back(advance_timer(req_cmd, req_channel, req_periodic,
                                                      req_ticks));
         end
      end
      pending      <= predicted_results.size();
      error_count  <= errors;
      result_count <= results;
      fire_count   <= fires;
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compare timer testbench
// Drives tick, start, stop and unused commands into the compare timer, first a
// directed set of corner cases and then bursts of random traffic, while the
// result side stalls on its own pattern. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import mcct_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 1300;
   localparam int         LONG_HOLD    = 300;
   localparam int         IDLE_LIMIT   = 5000;
   localparam int         DRAIN_CYCLES = 8;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd      = 2'd0;
   logic [1:0]  req_channel  = 2'd0;
   logic        req_periodic = 1'b0;
   logic [31:0] req_ticks    = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic [3:0]  rsp_fired;
   logic [3:0]  rsp_armed;

   int error_count;
   int pending;
   int result_count;
   int fire_count;
   int idle_cycles;
   int sent [4];
   bit hold_wanted = 1'b0;

   always #5 clock = ~clock;

   multi_channel_compare_timer_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_channel (req_channel),
      .req_periodic(req_periodic),
      .req_ticks   (req_ticks),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_fired   (rsp_fired),
      .rsp_armed   (rsp_armed)
   );

   mcct_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_channel (req_channel),
      .req_periodic(req_periodic),
      .req_ticks   (req_ticks),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_fired   (rsp_fired),
      .rsp_armed   (rsp_armed),
      .error_count (error_count),
      .pending     (pending),
      .result_count(result_count),
      .fire_count  (fire_count)
   );

   task automatic send_item(logic [1:0] cmd, logic [1:0] ch, logic per, logic [31:0] dly);
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_channel  <= ch;
      req_periodic <= per;
      req_ticks    <= dly;
      do @(posedge clock); while (req_stall);
      sent[cmd]++;
   endtask

   task automatic advance_ticks(int count);
      repeat (count) send_item(CMD_TICK, 2'($urandom), 1'($urandom), $urandom);
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : receiver
      int span;
      int mode;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 60);
            repeat (span) begin
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= 1'($urandom_range(0, 1));
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin : stimulus
      logic [1:0]  cmd;
      logic [1:0]  ch;
      logic        per;
      logic [31:0] dly;
      int          pick;
      int          burst;
      int          counted;
      bit          drained;
      counted = 0;
      drained = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed corner cases.
      advance_ticks(1);
      send_item(CMD_START, 2'd0, 1'b0, 32'd1);
      advance_ticks(1);
      send_item(CMD_START, 2'd1, 1'b1, 32'd2);
      advance_ticks(4);
      send_item(CMD_START, 2'd2, 1'b1, 32'd0);
      send_item(CMD_START, 2'd3, 1'b0, 32'hFFFF_FFFF);
      send_item(CMD_START, 2'd3, 1'b1, 32'd1);
      advance_ticks(1);
      send_item(CMD_STOP, 2'd1, 1'b1, 32'hFFFF_FFFF);
      send_item(CMD_STOP, 2'd1, 1'b0, 32'd0);
      send_item(CMD_STOP, 2'd2, 1'b0, 32'd0);
      send_item(CMD_UNUSED, 2'd3, 1'b1, 32'hFFFF_FFFF);
      send_item(CMD_START, 2'd0, 1'b1, 32'h8000_0000);
      send_item(CMD_STOP, 2'd0, 1'b0, 32'd0);
      send_item(CMD_START, 2'd0, 1'b0, 32'd3);
      send_item(CMD_START, 2'd1, 1'b1, 32'd3);
      advance_ticks(3);
      send_item(CMD_STOP, 2'd3, 1'b0, 32'd0);
      wait_for_drain();

      // Random traffic; the receiver is asked for one long hold-off.
      hold_wanted <= 1'b1;
      while (counted < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 30);
         for (int n = 0; n < burst && counted < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            ch   = 2'($urandom);
            per  = 1'($urandom);
            dly  = $urandom;
            if (pick < 58) begin
               cmd = CMD_TICK;
            end else if (pick < 82) begin
               cmd  = CMD_START;
               pick = $urandom_range(0, 99);
               if (pick < 70) begin
                  dly = $urandom_range(0, 12);
               end else if (pick < 85) begin
                  dly = $urandom_range(0, 200);
               end
            end else if (pick < 93) begin
               cmd = CMD_STOP;
            end else begin
               cmd = CMD_UNUSED;
            end
            send_item(cmd, ch, per, dly);
            counted++;
            if (!drained && counted >= RANDOM_ITEMS / 2) begin
               drained = 1'b1;
               wait_for_drain();
            end
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("Sent %0d ticks, %0d starts, %0d stops and %0d unused commands.",
               sent[CMD_TICK], sent[CMD_START], sent[CMD_STOP], sent[CMD_UNUSED]);
      $display("Checked %0d results with %0d channel firings, under a long output hold.",
               result_count, fire_count);
      if (error_count == 0 && pending == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ----- multi_channel_compare_timer_top.f -----
hw/rtl/mcct_pkg.sv
hw/rtl/mcct_cell.sv
hw/rtl/multi_channel_compare_timer_top.sv
sim/mcct_checker.sv
sim/testbench.sv
